### hdl/sukset_pkg.sv
package sukset_pkg;

	localparam int KEY_W    = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;

	localparam int CAPACITY_DEF = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// per-cycle shift command broadcast along the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

### hdl/sukset_cell.sv
module sukset_cell (
	input  logic                                  clk,
	input  sukset_pkg::cell_ctrl_t                ctrl,
	input  logic                                  occupied,
	input  logic signed [sukset_pkg::KEY_W-1:0]   key_i,
	input  logic signed [sukset_pkg::KEY_W-1:0]   left_key,
	input  logic                                  left_ge,
	input  logic signed [sukset_pkg::KEY_W-1:0]   right_key,
	output logic signed [sukset_pkg::KEY_W-1:0]   key_o,
	output logic                                  ge,
	output logic                                  hit,
	output logic                                  at
);

	logic signed [sukset_pkg::KEY_W-1:0] key_q;

	assign key_o = key_q;
	// an empty cell counts as not below the incoming key
	assign ge    = !(occupied && (key_q < key_i));
	assign hit   = occupied && (key_q == key_i);
	// first cell not below the key: the sorted slot
	assign at    = ge && !left_ge;

	always_ff @(posedge clk) begin
		if (ctrl.ins && ge) begin
			key_q <= left_ge ? left_key : key_i;
		end else if (ctrl.del && ge) begin
			key_q <= right_key;
		end
	end

endmodule

### hdl/sorted_unique_key_set.sv
// channel | direction | handshake              | fields
// req     | in        | req_valid / req_stall  | op, key
// rsp     | out       | rsp_valid / rsp_stall  | status, position, count
//
// one transaction per cycle unless req_stall: every cell compares its key with the
// request key, slot and hit are encoded and the row shifts at the same clock edge
// result sits in an output register; req_stall is high while it waits under rsp_stall
// reset clears the key count and the result valid; cell keys are left as they are
// and are never read beyond the count, so there is no clearing pass
module sorted_unique_key_set #(
	parameter int CAPACITY = sukset_pkg::CAPACITY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic [sukset_pkg::OP_W-1:0]            op,
	input  logic signed [sukset_pkg::KEY_W-1:0]    key,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic [sukset_pkg::STATUS_W-1:0]        status,
	output logic [sukset_pkg::POS_W-1:0]           position,
	output logic [sukset_pkg::CNT_W-1:0]           count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);

	logic signed [sukset_pkg::KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] ge_v, hit_v, at_v, occ_v;

	logic [CW-1:0] cnt_q;
	logic          rsp_valid_q;
	logic [sukset_pkg::STATUS_W-1:0] status_q;
	logic [sukset_pkg::POS_W-1:0]    position_q;
	logic [sukset_pkg::CNT_W-1:0]    count_q;

	logic fire, found, full, ins_do, del_do;
	logic [IDX_W-1:0] slot;
	logic [sukset_pkg::STATUS_W-1:0] status_d;
	logic [IDX_W-1:0] where_d;
	logic [CW-1:0] cnt_d;
	logic [sukset_pkg::POS_W+IDX_W-1:0] where_ext;
	logic [sukset_pkg::CNT_W+CW-1:0]    cnt_ext;
	sukset_pkg::cell_ctrl_t ctrl;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign found     = |hit_v;
	assign full      = (cnt_q == CW'(CAPACITY));

	always_comb begin
		slot = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (at_v[i]) slot = slot | IDX_W'(i);
		end
	end

	always_comb begin
		ins_do   = 1'b0;
		del_do   = 1'b0;
		status_d = sukset_pkg::ST_OK;
		where_d  = '0;
		priority if (op == sukset_pkg::OP_INSERT) begin
			if (found) begin
				status_d = sukset_pkg::ST_MISS;
			end else if (full) begin
				status_d = sukset_pkg::ST_FULL;
			end else begin
				ins_do  = fire;
				where_d = slot;
			end
		end else if (op == sukset_pkg::OP_DELETE) begin
			if (found) begin
				del_do  = fire;
				where_d = slot;
			end else begin
				status_d = sukset_pkg::ST_MISS;
			end
		end else begin
			// lookup, and the unused code acts as lookup
			if (found) where_d = slot;
			else status_d = sukset_pkg::ST_MISS;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ins_do) cnt_d = cnt_q + 1'b1;
		else if (del_do) cnt_d = cnt_q - 1'b1;
	end

	assign ctrl.ins  = ins_do;
	assign ctrl.del  = del_do;
	assign where_ext = {{sukset_pkg::POS_W{1'b0}}, where_d};
	assign cnt_ext   = {{sukset_pkg::CNT_W{1'b0}}, cnt_d};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign occ_v[g] = (CW'(g) < cnt_q);
		sukset_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (occ_v[g]),
			.key_i     (key),
			.left_key  ((g == 0) ? key : cell_key[(g == 0) ? 0 : g - 1]),
			.left_ge   ((g == 0) ? 1'b0 : ge_v[(g == 0) ? 0 : g - 1]),
			.right_key (cell_key[(g == CAPACITY - 1) ? g : g + 1]),
			.key_o     (cell_key[g]),
			.ge        (ge_v[g]),
			.hit       (hit_v[g]),
			.at        (at_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (fire) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q   <= status_d;
			position_q <= where_ext[sukset_pkg::POS_W-1:0];
			count_q    <= cnt_ext[sukset_pkg::CNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = count_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_v))
		else $error("key held in more than one cell");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(at_v))
		else $error("more than one sorted slot");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_do |=> (cnt_q == $past(cnt_q) + 1'b1) && rsp_valid_q)
		else $error("insert did not grow the count");

	a_hit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> |(hit_v & at_v))
		else $error("hit cell is not the sorted slot");
`endif

endmodule

### sim/sukset_scoreboard_pkg.sv
package sukset_scoreboard_pkg;

	import sukset_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [CNT_W-1:0]    count;
	} key_set_result_t;

	class key_set_scoreboard;
		int                       capacity;
		logic signed [KEY_W-1:0]  held_keys[$];
		key_set_result_t          awaited_results[$];
		int unsigned              mismatches;
		int unsigned              n_insert, n_delete, n_lookup;
		int unsigned              n_ok, n_miss, n_full;
		int unsigned              peak_count;

		function new(int cap);
			capacity   = cap;
			mismatches = 0;
			n_insert   = 0;
			n_delete   = 0;
			n_lookup   = 0;
			n_ok       = 0;
			n_miss     = 0;
			n_full     = 0;
			peak_count = 0;
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		// predicts the result of one accepted request and updates the held set
		function void note_request(logic [OP_W-1:0] op_code, logic signed [KEY_W-1:0] k);
			int              slot;
			bit              hit;
			key_set_result_t r;
			slot = 0;
			foreach (held_keys[i])
				if (held_keys[i] < k)
					slot++;
			hit        = (slot < held_keys.size()) && (held_keys[slot] == k);
			r.status   = ST_OK;
			r.position = '0;
			case (op_code)
				OP_INSERT: begin
					n_insert++;
					if (hit)
						r.status = ST_MISS;
					else if (held_keys.size() >= capacity)
						r.status = ST_FULL;
					else begin
						held_keys.insert(slot, k);
						r.position = POS_W'(slot);
					end
				end
				OP_DELETE: begin
					n_delete++;
					if (!hit)
						r.status = ST_MISS;
					else begin
						held_keys.delete(slot);
						r.position = POS_W'(slot);
					end
				end
				// the spare code behaves as a lookup
				default: begin
					n_lookup++;
					if (hit)
						r.position = POS_W'(slot);
					else
						r.status = ST_MISS;
				end
			endcase
			r.count = CNT_W'(held_keys.size());
			if (held_keys.size() > peak_count)
				peak_count = held_keys.size();
			case (r.status)
				ST_OK:   n_ok++;
				ST_MISS: n_miss++;
				default: n_full++;
			endcase
			awaited_results.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
				logic [CNT_W-1:0] cnt);
			key_set_result_t exp_r;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result status %0d position %0d count %0d",
					st, pos, cnt));
			end else begin
				exp_r = awaited_results.pop_front();
				if (st !== exp_r.status)
					report($sformatf("status %0d, predicted %0d", st, exp_r.status));
				if (pos !== exp_r.position)
					report($sformatf("position %0d, predicted %0d", pos, exp_r.position));
				if (cnt !== exp_r.count)
					report($sformatf("count %0d, predicted %0d", cnt, exp_r.count));
			end
		endtask
	endclass

endpackage

### sim/sorted_unique_key_set_tb.sv
module sorted_unique_key_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sukset_pkg::*;
	import sukset_scoreboard_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_RANDOM    = 525;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	logic [OP_W-1:0]            op;
	logic signed [KEY_W-1:0]    key;
	logic                       rsp_valid;
	logic                       rsp_stall;
	logic [STATUS_W-1:0]        status;
	logic [POS_W-1:0]           position;
	logic [CNT_W-1:0]           count;

	key_set_scoreboard          sb;
	logic signed [KEY_W-1:0]    key_pool[24];
	bit                         hold_off_req;

	sorted_unique_key_set #(.CAPACITY(CAP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.position  (position),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// pooled keys give duplicates, hits and a full store often enough
	function automatic logic signed [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 75)
			return key_pool[$urandom_range(0, 23)];
		else
			return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int idx);
		int unsigned r;
		int unsigned ins_w;
		int unsigned del_w;
		r = $urandom_range(0, 99);
		case ((idx / 70) % 3)
			0:       begin ins_w = 60; del_w = 15; end
			1:       begin ins_w = 20; del_w = 55; end
			default: begin ins_w = 40; del_w = 35; end
		endcase
		if (r < ins_w)
			return OP_INSERT;
		else if (r < ins_w + del_w)
			return OP_DELETE;
		else if (r < 95)
			return OP_LOOKUP;
		else
			return 2'd3;
	endfunction

	task automatic send_request(input logic [OP_W-1:0] o, input logic signed [KEY_W-1:0] k,
			input bit no_gap);
		int unsigned g;
		g = no_gap ? 0 : pick_gap();
		if (g != 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		key       <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// scoreboard sees every transaction on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(op, key);
			if (rsp_valid && !rsp_stall)
				sb.check_result(status, position, count);
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		int unsigned n;
		bit          hold_done;
		hold_done = 1'b0;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (hold_off_req && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (n != 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
				idle = 0;
			else
				idle++;
		end
		$display("no transaction for %0d cycles", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		bit burst;
		sb           = new(CAP);
		hold_off_req = 1'b0;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		op          <= OP_INSERT;
		key         <= '0;

		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < 12; i++)
			key_pool[i] = $urandom_range(0, 40) - 20;
		for (int i = 12; i < 24; i++)
			key_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, then the extremes of the key range
		send_request(OP_LOOKUP, 32'sd5, 1'b0);
		send_request(OP_DELETE, 32'sd5, 1'b0);
		send_request(OP_INSERT, 32'sd0, 1'b0);
		send_request(OP_INSERT, 32'sh8000_0000, 1'b0);
		send_request(OP_INSERT, 32'sh7fff_ffff, 1'b0);
		send_request(OP_INSERT, -32'sd1, 1'b0);
		send_request(OP_INSERT, 32'sd1, 1'b0);
		send_request(OP_INSERT, 32'sd0, 1'b0);
		send_request(OP_LOOKUP, 32'sh8000_0000, 1'b0);
		send_request(2'd3, 32'sh7fff_ffff, 1'b0);
		send_request(OP_LOOKUP, 32'sd5, 1'b0);
		send_request(OP_DELETE, -32'sd1, 1'b0);
		send_request(OP_DELETE, -32'sd1, 1'b0);
		// fill up, then insert a new key and a held key while full
		for (int i = 0; i < 12; i++)
			send_request(OP_INSERT, 32'sd100 + i * 7, 1'b0);
		send_request(OP_INSERT, 32'sd5000, 1'b0);
		send_request(OP_INSERT, 32'sd107, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 150)
				hold_off_req = 1'b1;
			burst = ((i / 60) % 4) == 1;
			send_request(pick_op(i), pick_key(), burst);
		end
		req_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests: %0d insert, %0d delete, %0d lookup; up to %0d keys held",
			sb.n_insert + sb.n_delete + sb.n_lookup, sb.n_insert, sb.n_delete, sb.n_lookup,
			sb.peak_count);
		$display("outcomes: %0d done or found, %0d duplicate or absent, %0d full; %0d mismatches",
			sb.n_ok, sb.n_miss, sb.n_full, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
